// ----- sv/iohist_pkg.sv -----
// Shared types and constants of the interval occupancy histogram.
package iohist_pkg;

  localparam int FIELD_W = 32;
  localparam int IDX_W   = 5;
  localparam int CNT_W   = 6;
  localparam int ACC_W   = 40;
  localparam int QDEPTH  = 2;

  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [IDX_W-1:0]   idx;
    logic               rd_ok;
    logic [FIELD_W-1:0] val_a;
    logic [FIELD_W-1:0] val_b;
  } op_t;

endpackage

// ----- sv/iohist_ifs.sv -----
// Valid/ready channel interfaces for command words and result words.
interface iohist_in_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         command;
  logic [iohist_pkg::IDX_W-1:0]       index;
  logic [iohist_pkg::FIELD_W-1:0]     edge_value;
  logic [iohist_pkg::FIELD_W-1:0]     start_time;
  logic [iohist_pkg::FIELD_W-1:0]     end_time;

  modport source (output valid, command, index, edge_value, start_time, end_time,
                  input ready);
  modport sink   (input valid, command, index, edge_value, start_time, end_time,
                  output ready);
endinterface

interface iohist_out_if;
  logic                             valid;
  logic                             ready;
  logic [iohist_pkg::IDX_W-1:0]     read_index;
  logic [iohist_pkg::ACC_W-1:0]     bin_value;

  modport source (output valid, read_index, bin_value, input ready);
  modport sink   (input valid, read_index, bin_value, output ready);
endinterface

// ----- sv/iohist_front.sv -----
// Front end: takes command words, masks times and drops commands that do nothing.
module iohist_front #(
  parameter int MAX_EDGES = 32,
  parameter int TIME_BITS = 32
) (
  iohist_in_if.sink          in_bus,
  input  logic               init_done,
  input  logic               q_ready,
  output logic               q_push,
  output iohist_pkg::op_t    q_op
);
  import iohist_pkg::*;

  localparam int TW = (TIME_BITS < FIELD_W) ? TIME_BITS : FIELD_W;
  localparam logic [FIELD_W-1:0] TMASK = {FIELD_W{1'b1}} >> (FIELD_W - TW);

  cmd_t               cmd;
  logic               keep;
  logic [FIELD_W-1:0] s_m;
  logic [FIELD_W-1:0] e_m;

  assign cmd = cmd_t'(in_bus.command);
  assign s_m = in_bus.start_time & TMASK;
  assign e_m = in_bus.end_time & TMASK;

  always_comb begin
    keep        = 1'b1;
    q_op.cmd    = cmd;
    q_op.idx    = in_bus.index;
    q_op.rd_ok  = int'(in_bus.index) < (MAX_EDGES - 1);
    q_op.val_a  = s_m;
    q_op.val_b  = e_m;
    unique case (cmd)
      CMD_LOAD: begin
        keep       = int'(in_bus.index) < MAX_EDGES;
        q_op.val_a = in_bus.edge_value & TMASK;
      end
      CMD_ADD: begin
        // A reversed interval adds nothing.
        keep = (e_m >= s_m);
      end
      CMD_READ: begin
        keep = 1'b1;
      end
      CMD_CLEAR: begin
        keep = 1'b1;
      end
    endcase
  end

  assign in_bus.ready = q_ready && init_done;
  assign q_push       = in_bus.valid && in_bus.ready && keep;

endmodule

// ----- sv/iohist_fifo.sv -----
// Short command queue between the front end and the histogram engine.
module iohist_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  iohist_pkg::op_t   push_op,
  output logic              push_ready,
  input  logic              pop,
  output logic              head_valid,
  output iohist_pkg::op_t   head_op
);
  import iohist_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  op_t           slot_r [QDEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_op;
    end
  end

  assign push_ready = (cnt_r != (PW+1)'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_op    = slot_r[rp_r];

endmodule

// ----- sv/iohist_back.sv -----
// Histogram engine: edge store, bin store, edge scan and per-bin accumulation.
module iohist_back #(
  parameter int MAX_EDGES = 32,
  parameter int TIME_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [iohist_pkg::CNT_W-1:0]  edge_count,
  input  logic                          q_valid,
  input  iohist_pkg::op_t               q_op,
  output logic                          q_pop,
  output logic                          init_done,
  iohist_out_if.source                  out_bus
);
  import iohist_pkg::*;

  localparam int TW = (TIME_BITS < FIELD_W) ? TIME_BITS : FIELD_W;
  localparam int AW = (MAX_EDGES > 2) ? $clog2(MAX_EDGES) : 1;
  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam int NB = MAX_EDGES - 1;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_READ   = 6'b000100,
    S_SCAN   = 6'b001000,
    S_DECIDE = 6'b010000,
    S_ACC    = 6'b100000
  } state_t;

  // Stores and their registered read data.
  logic [TW-1:0]    edge_mem [MAX_EDGES];
  logic [ACC_W-1:0] bin_mem  [NB];
  logic [TW-1:0]    rd0_r, rd1_r;
  logic [ACC_W-1:0] bin_rd_r;

  logic             edge_we, bin_we;
  logic [AW-1:0]    edge_wa, bin_wa, ra0, ra1, bin_ra;
  logic [TW-1:0]    edge_wd;
  logic [ACC_W-1:0] bin_wd;

  state_t           state_r, state_nxt;
  logic [AW-1:0]    clr_k_r, clr_k_nxt;
  logic             init_done_r, init_done_nxt;
  logic [AW-1:0]    k_r, k_nxt;
  logic             iss_done_r, iss_done_nxt;
  logic             dv_r, dv_nxt;
  logic [AW-1:0]    kd_r, kd_nxt;
  logic             cv_r, cv_nxt;
  logic [AW-1:0]    kc_r, kc_nxt;
  logic [TW-1:0]    len_r, len_nxt;
  logic [ACC_W-1:0] bd_r, bd_nxt;

  logic [TW-1:0]    s_r, s_nxt, e_r, e_nxt;
  logic [TW-1:0]    e0_r, e0_nxt, el_r, el_nxt;
  logic             sf_r, sf_nxt, ea_f_r, ea_f_nxt, ef_f_r, ef_f_nxt;
  logic [AW-1:0]    sb_r, sb_nxt, eb_r, eb_nxt;
  logic [AW-1:0]    ea_b_r, ea_b_nxt, ef_b_r, ef_b_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             rd_ok_r, rd_ok_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0] out_idx_r, out_idx_nxt;
  logic [ACC_W-1:0] out_val_r, out_val_nxt;

  logic [CW-1:0]    n_use;
  logic [AW-1:0]    last_bin;
  logic             out_free;
  logic             s_hit, e_hit;
  logic [TW-1:0]    lo_b, hi_b, len_b;
  logic [ACC_W:0]   sum_c;
  logic [ACC_W-1:0] sat_c;
  logic             e_found;
  logic [AW-1:0]    e_bin;

  // Edges in use, held between two and the store depth.
  always_comb begin
    if (int'(edge_count) > MAX_EDGES) begin
      n_use = CW'(MAX_EDGES);
    end else if (int'(edge_count) < 2) begin
      n_use = CW'(2);
    end else begin
      n_use = CW'(edge_count);
    end
    last_bin = AW'(n_use - CW'(2));
  end

  assign out_free = !out_valid_r || out_bus.ready;

  assign s_hit = (s_r >= rd0_r) && (s_r <= rd1_r);
  assign e_hit = (e_r >= rd0_r) && (e_r <= rd1_r);

  // Overlap of bin kd with the cropped interval; the end bins use the interval's own ends.
  assign lo_b  = (kd_r == sb_r) ? s_r : rd0_r;
  assign hi_b  = (kd_r == eb_r) ? e_r : rd1_r;
  assign len_b = (hi_b > lo_b) ? (hi_b - lo_b) : '0;

  assign sum_c = {1'b0, bd_r} + (ACC_W+1)'(len_r);
  assign sat_c = sum_c[ACC_W] ? ACC_MAX : sum_c[ACC_W-1:0];

  assign e_found = sf_r ? ef_f_r : ea_f_r;
  assign e_bin   = sf_r ? ef_b_r : ea_b_r;

  always_comb begin
    state_nxt     = state_r;
    clr_k_nxt     = clr_k_r;
    init_done_nxt = init_done_r;
    k_nxt         = k_r;
    iss_done_nxt  = iss_done_r;
    dv_nxt        = 1'b0;
    kd_nxt        = k_r;
    cv_nxt        = 1'b0;
    kc_nxt        = kd_r;
    len_nxt       = len_b;
    bd_nxt        = bin_rd_r;
    s_nxt         = s_r;
    e_nxt         = e_r;
    e0_nxt        = e0_r;
    el_nxt        = el_r;
    sf_nxt        = sf_r;
    ea_f_nxt      = ea_f_r;
    ef_f_nxt      = ef_f_r;
    sb_nxt        = sb_r;
    eb_nxt        = eb_r;
    ea_b_nxt      = ea_b_r;
    ef_b_nxt      = ef_b_r;
    idx_nxt       = idx_r;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;
    out_idx_nxt   = out_idx_r;
    out_val_nxt   = out_val_r;
    q_pop         = 1'b0;
    edge_we       = 1'b0;
    edge_wa       = AW'(q_op.idx);
    edge_wd       = TW'(q_op.val_a);
    bin_we        = 1'b0;
    bin_wa        = kc_r;
    bin_wd        = sat_c;
    ra0           = k_r;
    ra1           = k_r + 1'b1;
    bin_ra        = k_r;

    unique case (state_r)
      S_CLEAR: begin
        bin_we = 1'b1;
        bin_wa = clr_k_r;
        bin_wd = '0;
        if (clr_k_r == AW'(NB - 1)) begin
          state_nxt     = S_IDLE;
          init_done_nxt = 1'b1;
        end else begin
          clr_k_nxt = clr_k_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (q_valid) begin
          unique case (q_op.cmd)
            CMD_LOAD: begin
              edge_we = 1'b1;
              q_pop   = 1'b1;
            end
            CMD_CLEAR: begin
              q_pop     = 1'b1;
              clr_k_nxt = '0;
              state_nxt = S_CLEAR;
            end
            CMD_READ: begin
              if (out_free) begin
                q_pop     = 1'b1;
                bin_ra    = AW'(q_op.idx);
                idx_nxt   = q_op.idx;
                rd_ok_nxt = q_op.rd_ok;
                state_nxt = S_READ;
              end
            end
            CMD_ADD: begin
              q_pop        = 1'b1;
              s_nxt        = TW'(q_op.val_a);
              e_nxt        = TW'(q_op.val_b);
              k_nxt        = '0;
              iss_done_nxt = 1'b0;
              sf_nxt       = 1'b0;
              ea_f_nxt     = 1'b0;
              ef_f_nxt     = 1'b0;
              state_nxt    = S_SCAN;
            end
          endcase
        end
      end

      S_READ: begin
        out_valid_nxt = 1'b1;
        out_idx_nxt   = idx_r;
        out_val_nxt   = rd_ok_r ? bin_rd_r : '0;
        state_nxt     = S_IDLE;
      end

      S_SCAN: begin
        if (!iss_done_r) begin
          dv_nxt = 1'b1;
          if (k_r == last_bin) begin
            iss_done_nxt = 1'b1;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
        if (dv_r) begin
          if (kd_r == '0) begin
            e0_nxt = rd0_r;
          end
          if (!sf_r && s_hit) begin
            sf_nxt = 1'b1;
            sb_nxt = kd_r;
          end
          if (!ea_f_r && e_hit) begin
            ea_f_nxt = 1'b1;
            ea_b_nxt = kd_r;
          end
          // The end bin is searched from the start bin onwards.
          if (!ef_f_r && e_hit && (sf_r || s_hit)) begin
            ef_f_nxt = 1'b1;
            ef_b_nxt = kd_r;
          end
          if (kd_r == last_bin) begin
            el_nxt    = rd1_r;
            state_nxt = S_DECIDE;
          end
        end
      end

      S_DECIDE: begin
        if ((e_r < e0_r) || (s_r > el_r)) begin
          state_nxt = S_IDLE;
        end else begin
          if (!sf_r) begin
            s_nxt  = e0_r;
            sb_nxt = '0;
          end
          if (e_found) begin
            eb_nxt = e_bin;
          end else begin
            eb_nxt = last_bin;
            e_nxt  = el_r;
          end
          k_nxt        = sf_r ? sb_r : '0;
          iss_done_nxt = 1'b0;
          state_nxt    = S_ACC;
        end
      end

      S_ACC: begin
        if (!iss_done_r) begin
          dv_nxt = 1'b1;
          if (k_r == eb_r) begin
            iss_done_nxt = 1'b1;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
        if (dv_r) begin
          cv_nxt = 1'b1;
        end
        if (cv_r) begin
          bin_we = 1'b1;
          if (kc_r == eb_r) begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_k_r     <= '0;
      init_done_r <= 1'b0;
      iss_done_r  <= 1'b1;
      dv_r        <= 1'b0;
      cv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_k_r     <= clr_k_nxt;
      init_done_r <= init_done_nxt;
      iss_done_r  <= iss_done_nxt;
      dv_r        <= dv_nxt;
      cv_r        <= cv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r       <= k_nxt;
    kd_r      <= kd_nxt;
    kc_r      <= kc_nxt;
    len_r     <= len_nxt;
    bd_r      <= bd_nxt;
    s_r       <= s_nxt;
    e_r       <= e_nxt;
    e0_r      <= e0_nxt;
    el_r      <= el_nxt;
    sf_r      <= sf_nxt;
    ea_f_r    <= ea_f_nxt;
    ef_f_r    <= ef_f_nxt;
    sb_r      <= sb_nxt;
    eb_r      <= eb_nxt;
    ea_b_r    <= ea_b_nxt;
    ef_b_r    <= ef_b_nxt;
    idx_r     <= idx_nxt;
    rd_ok_r   <= rd_ok_nxt;
    out_idx_r <= out_idx_nxt;
    out_val_r <= out_val_nxt;
  end

  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[edge_wa] <= edge_wd;
    end
    rd0_r <= edge_mem[ra0];
    rd1_r <= edge_mem[ra1];
  end

  always_ff @(posedge clk) begin
    if (bin_we) begin
      bin_mem[bin_wa] <= bin_wd;
    end
    bin_rd_r <= bin_mem[bin_ra];
  end

  assign init_done          = init_done_r;
  assign out_bus.valid      = out_valid_r;
  assign out_bus.read_index = out_idx_r;
  assign out_bus.bin_value  = out_val_r;

  a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_READ))
    else $error("result word raised without a bin read");

  a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> !out_valid_r)
    else $error("bin read data arrived while the result register was full");

  a_no_pop_before_init: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> init_done_r)
    else $error("command taken before the bin clearing pass finished");

  a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC) |-> (sb_r <= eb_r) && (eb_r <= last_bin))
    else $error("accumulation range out of order");

  a_acc_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC && cv_r) |-> (kc_r >= sb_r) && (kc_r <= eb_r))
    else $error("bin written outside the spanned range");

endmodule

// ----- sv/interval_occupancy_histogram_core.sv -----
// Top level of the interval occupancy histogram.
// Usage:
//   Command words arrive on in_bus (valid/ready). Load edge writes one bin edge,
//   add interval spreads an interval's length over the bins it overlaps, read bin
//   returns one total on out_bus, clear zeroes all totals. Only a read gives a word.
//   cfg_wr_en/cfg_wr_data set the number of edges in use; write it only while idle.
// Timing:
//   A word passes the front end into a two-entry queue in the cycle it is taken.
//   A load writes the edge store as the engine pops it; a read fetches its bin
//   in S_READ and then registers the result word for out_bus. An add scans every
//   pair of edges in use, one pair a cycle through the single read port pair of the
//   edge store, and then updates the spanned bins one a cycle. A clear zeroes the
//   MAX_EDGES - 1 bins, one bin a cycle.
// Reset and stalls:
//   After reset the bin totals are zeroed in a pass over every bin with
//   in_bus.ready low; edges hold nothing until loaded. The result register holds a
//   word while out_bus.ready is low; loads, adds and clears go on meanwhile and only
//   a following read waits.
module interval_occupancy_histogram_core #(
  parameter int MAX_EDGES = 32,
  parameter int TIME_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [iohist_pkg::CNT_W-1:0]  cfg_wr_data,
  iohist_in_if.sink                     in_bus,
  iohist_out_if.source                  out_bus
);
  import iohist_pkg::*;

  logic [CNT_W-1:0] edge_count_r, edge_count_nxt;
  logic             init_done;
  logic             q_push, q_ready, q_pop, q_valid;
  op_t              push_op, head_op;

  assign edge_count_nxt = cfg_wr_en ? cfg_wr_data : edge_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_count_r <= CNT_W'(2);
    end else begin
      edge_count_r <= edge_count_nxt;
    end
  end

  iohist_front #(
    .MAX_EDGES (MAX_EDGES),
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .in_bus    (in_bus),
    .init_done (init_done),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_op      (push_op)
  );

  iohist_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_op    (push_op),
    .push_ready (q_ready),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_op    (head_op)
  );

  iohist_back #(
    .MAX_EDGES (MAX_EDGES),
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .edge_count (edge_count_r),
    .q_valid    (q_valid),
    .q_op       (head_op),
    .q_pop      (q_pop),
    .init_done  (init_done),
    .out_bus    (out_bus)
  );

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the interval occupancy histogram core.
module tb_top;
  import iohist_pkg::*;

  localparam int BINS        = 31;
  localparam int SETTLE      = 300;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    cmd_t               cmd;
    logic [IDX_W-1:0]   idx;
    logic [FIELD_W-1:0] edge_v;
    logic [FIELD_W-1:0] t_start;
    logic [FIELD_W-1:0] t_end;
  } cmd_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] bin;
    logic [ACC_W-1:0] total;
  } bin_report_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [CNT_W-1:0] cfg_wr_data;

  iohist_in_if  in_bus();
  iohist_out_if out_bus();

  interval_occupancy_histogram_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_bus      (in_bus),
    .out_bus     (out_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the block's state, updated as each word is accepted.
  logic [FIELD_W-1:0] edge_mirror [0:31];
  logic [ACC_W-1:0]   bin_mirror [0:BINS-1];
  logic [CNT_W-1:0]   edge_setting;

  cmd_word_t   cmd_backlog [$];
  bin_report_t due_totals [$];

  // Edge table as the stimulus generator last loaded it.
  logic [FIELD_W-1:0] gen_edges [0:31];

  int fault_count = 0;
  int send_gap;
  int recv_hold;
  int idle_cycles = 0;
  bit steady = 1'b0;

  function automatic int edges_used(logic [CNT_W-1:0] setting);
    if (setting < 2) return 2;
    if (setting > 32) return 32;
    return int'(setting);
  endfunction

  function automatic void bump_bin(int b, logic [FIELD_W-1:0] len);
    logic [ACC_W:0] sum;
    sum = {1'b0, bin_mirror[b]} + len;
    bin_mirror[b] = sum > {1'b0, ACC_MAX} ? ACC_MAX : sum[ACC_W-1:0];
  endfunction

  function automatic logic [FIELD_W-1:0] floor_gap(logic [FIELD_W-1:0] a,
                                                   logic [FIELD_W-1:0] b);
    return a > b ? a - b : '0;
  endfunction

  function automatic void spread_interval(logic [FIELD_W-1:0] s_in,
                                          logic [FIELD_W-1:0] e_in);
    int n, nb, sb, eb, k;
    logic [FIELD_W-1:0] s, e;
    s = s_in;
    e = e_in;
    n = edges_used(edge_setting);
    nb = n - 1;
    sb = -1;
    eb = -1;
    if (e < s) return;
    if (e < edge_mirror[0] || s > edge_mirror[n-1]) return;
    for (k = 0; k < nb && sb < 0; k++)
      if (s >= edge_mirror[k] && s <= edge_mirror[k+1]) sb = k;
    if (sb < 0) begin
      s = edge_mirror[0];
      sb = 0;
    end
    for (k = sb; k < nb && eb < 0; k++)
      if (e >= edge_mirror[k] && e <= edge_mirror[k+1]) eb = k;
    if (eb < 0) begin
      e = edge_mirror[n-1];
      eb = nb - 1;
    end
    if (sb == eb) begin
      bump_bin(sb, floor_gap(e, s));
    end else begin
      bump_bin(sb, floor_gap(edge_mirror[sb+1], s));
      bump_bin(eb, floor_gap(e, edge_mirror[eb]));
      for (k = sb + 1; k < eb; k++)
        bump_bin(k, floor_gap(edge_mirror[k+1], edge_mirror[k]));
    end
  endfunction

  function automatic void apply_word();
    bin_report_t r;
    case (in_bus.command)
      CMD_LOAD: edge_mirror[in_bus.index] = in_bus.edge_value;
      CMD_ADD:  spread_interval(in_bus.start_time, in_bus.end_time);
      CMD_READ: begin
        r.bin = in_bus.index;
        r.total = in_bus.index < BINS ? bin_mirror[in_bus.index] : '0;
        due_totals.push_back(r);
      end
      default: for (int b = 0; b < BINS; b++) bin_mirror[b] = '0;
    endcase
  endfunction

  function automatic void note_fault(string msg);
    fault_count++;
    if (fault_count <= 10) $display("%s", msg);
  endfunction

  function automatic void check_total(logic [IDX_W-1:0] bin, logic [ACC_W-1:0] total);
    bin_report_t want;
    if (due_totals.size() == 0) begin
      note_fault($sformatf("unexpected word: bin %0d total %0d", bin, total));
    end else begin
      want = due_totals.pop_front();
      if (want.bin !== bin || want.total !== total)
        note_fault($sformatf("mismatch: expected bin %0d total %0d, got bin %0d total %0d",
                             want.bin, want.total, bin, total));
    end
  endfunction

  // Back to back when steady; else mostly back to back, sometimes a short gap, now and then a long pause.
  function automatic int draw_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin : driver
    cmd_word_t w;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_bus.valid && in_bus.ready) apply_word();
      if (!in_bus.valid || in_bus.ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_bus.valid <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          w = cmd_backlog.pop_front();
          in_bus.command <= w.cmd;
          in_bus.index <= w.idx;
          in_bus.edge_value <= w.edge_v;
          in_bus.start_time <= w.t_start;
          in_bus.end_time <= w.t_end;
          in_bus.valid <= 1'b1;
          send_gap <= draw_gap();
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      recv_hold <= 0;
    end else begin
      if (out_bus.valid && out_bus.ready) check_total(out_bus.read_index, out_bus.bin_value);
      if (recv_hold != 0) begin
        recv_hold <= recv_hold - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
        if (!steady && $urandom_range(0, 99) < 20) recv_hold <= draw_gap();
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [FIELD_W-1:0] between(longint unsigned lo, longint unsigned hi);
    longint unsigned t;
    if (hi < lo) begin
      t = lo;
      lo = hi;
      hi = t;
    end
    return FIELD_W'(lo + ({$urandom, $urandom} % (hi - lo + 1)));
  endfunction

  task automatic push_word(cmd_t c, int idx, logic [FIELD_W-1:0] ev,
                           logic [FIELD_W-1:0] s, logic [FIELD_W-1:0] e);
    cmd_word_t w;
    w.cmd = c;
    w.idx = IDX_W'(idx);
    w.edge_v = ev;
    w.t_start = s;
    w.t_end = e;
    if (c == CMD_LOAD) gen_edges[idx] = ev;
    cmd_backlog.push_back(w);
  endtask

  task automatic load_edge(int idx, logic [FIELD_W-1:0] v);
    push_word(CMD_LOAD, idx, v, $urandom, $urandom);
  endtask

  task automatic add_span(logic [FIELD_W-1:0] s, logic [FIELD_W-1:0] e);
    push_word(CMD_ADD, $urandom_range(0, 31), $urandom, s, e);
  endtask

  task automatic read_bin(int idx);
    push_word(CMD_READ, idx, $urandom, $urandom, $urandom);
  endtask

  task automatic clear_bins();
    push_word(CMD_CLEAR, $urandom_range(0, 31), $urandom, $urandom, $urandom);
  endtask

  // Waits until the sender has nothing left and every read has been answered.
  task automatic drain();
    while (cmd_backlog.size() != 0 || in_bus.valid || due_totals.size() != 0)
      @(posedge clk);
  endtask

  task automatic set_edge_count(logic [CNT_W-1:0] v);
    drain();
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    edge_setting = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic load_ascending(int n);
    longint unsigned v, step_max;
    v = $urandom_range(0, 1 << 20);
    step_max = (64'hFFFF_FFFF - v) / n;
    for (int k = 0; k < n; k++) begin
      load_edge(k, FIELD_W'(v));
      v += between(0, step_max);
    end
  endtask

  function automatic logic [FIELD_W-1:0] pick_time(int n);
    longint unsigned lo, hi;
    int r;
    lo = gen_edges[0];
    hi = gen_edges[n-1];
    if (hi < lo) begin
      lo = gen_edges[n-1];
      hi = gen_edges[0];
    end
    r = $urandom_range(0, 99);
    if (r < 65) return between(lo, hi);
    if (r < 80) return gen_edges[$urandom_range(0, n - 1)];
    if (r < 88) return between(0, lo);
    if (r < 94) return between(hi, 64'hFFFF_FFFF);
    return $urandom;
  endfunction

  task automatic random_words(int n, int count, bit wild);
    int r, idx;
    logic [FIELD_W-1:0] a, b, v;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        a = pick_time(n);
        b = pick_time(n);
        r = $urandom_range(0, 99);
        if (r < 75) add_span(a < b ? a : b, a < b ? b : a);
        else if (r < 83) add_span(a < b ? b : a, a < b ? a : b);
        else if (r < 90) add_span(a, a);
        else add_span(a, b);
      end else if (r < 80) begin
        read_bin($urandom_range(0, 99) < 85 ? $urandom_range(0, n - 2) : $urandom_range(0, 31));
      end else if (r < 95) begin
        idx = $urandom_range(0, 31);
        // Keep the table ascending unless this setting is meant to break it.
        if (wild || idx >= n) v = $urandom;
        else if (idx == 0) v = between(0, gen_edges[1]);
        else if (idx == n - 1) v = between(gen_edges[n-2], 64'hFFFF_FFFF);
        else v = between(gen_edges[idx-1], gen_edges[idx+1]);
        load_edge(idx, v);
      end else begin
        clear_bins();
      end
    end
  endtask

  task automatic run_setting(logic [CNT_W-1:0] setting, int count, bit wild);
    int n;
    n = edges_used(setting);
    set_edge_count(setting);
    if (wild) for (int k = 0; k < n; k++) load_edge(k, $urandom);
    else load_ascending(n);
    random_words(n, count / 2, wild);
    // Let everything drain mid-setting before the second half goes out.
    drain();
    random_words(n, count - count / 2, wild);
  endtask

  initial begin
    logic [CNT_W-1:0] later_settings [6];
    later_settings = '{6'd5, 6'd1, 6'd17, 6'd33, 6'd3, 6'd31};
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_bus.valid = 1'b0;
    in_bus.command = CMD_LOAD;
    in_bus.index = '0;
    in_bus.edge_value = '0;
    in_bus.start_time = '0;
    in_bus.end_time = '0;
    out_bus.ready = 1'b0;
    for (int k = 0; k < 32; k++) edge_mirror[k] = '0;
    for (int b = 0; b < BINS; b++) bin_mirror[b] = '0;
    edge_setting = 6'd2;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // The block zeroes its totals after reset before it takes any word.
    while (!in_bus.ready) @(posedge clk);

    set_edge_count(6'd2);
    read_bin(0);
    read_bin(31);
    read_bin(30);
    load_edge(0, 32'h0000_0000);
    load_edge(1, 32'hFFFF_FFFF);
    add_span(32'h0000_0000, 32'hFFFF_FFFF);
    add_span(32'hFFFF_FFFF, 32'h0000_0000);
    add_span(32'd5, 32'd5);
    read_bin(0);
    clear_bins();
    read_bin(0);
    load_edge(0, 32'd1000);
    load_edge(1, 32'd2000);
    add_span(32'd0, 32'd500);
    add_span(32'd2500, 32'd3000);
    add_span(32'd500, 32'd1500);
    add_span(32'd1500, 32'd2500);
    add_span(32'd0, 32'hFFFF_FFFF);
    read_bin(0);
    // Edges in descending order: the first add falls outside and the second crops to zero length.
    load_edge(0, 32'd3000);
    add_span(32'd2500, 32'd3500);
    add_span(32'd0, 32'd5000);
    read_bin(0);
    load_edge(31, 32'hFFFF_FFFF);

    // One bin over the whole time range, filled until it saturates.
    set_edge_count(6'd0);
    load_edge(0, 32'h0000_0000);
    load_edge(1, 32'hFFFF_FFFF);
    for (int i = 0; i < 300; i++) begin
      if ($urandom_range(0, 99) < 95)
        add_span($urandom_range(0, 255), $urandom_range(32'hFFFF_FF00, 32'hFFFF_FFFF));
      else
        read_bin($urandom_range(0, 3) == 0 ? $urandom_range(0, 31) : 0);
    end

    run_setting(6'd32, 260, 1'b0);
    run_setting(6'd63, 300, 1'b1);
    foreach (later_settings[i]) begin
      steady = (i % 3 == 2);
      run_setting(later_settings[i], 110, i % 2 == 1);
    end
    steady = 1'b0;

    drain();
    repeat (SETTLE) @(posedge clk);
    if (fault_count == 0 && due_totals.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/iohist_pkg.sv
sv/iohist_ifs.sv
sv/iohist_front.sv
sv/iohist_fifo.sv
sv/iohist_back.sv
sv/interval_occupancy_histogram_core.sv
tb/tb_top.sv
